>>> hdl/rcbd_pkg.sv
// Shared types, constants and helper functions for the rotation codebook byte decrypt unit.
// No dependencies.
package rcbd_pkg;

	localparam int TOKEN_W       = 16;
	localparam int SYM_W         = 4;
	localparam int ROTS          = 16;
	localparam int REG_BOOKS     = 4;
	localparam int SALT_W        = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int BOOK_COUNT_DEF = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SALT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE0 = 3'd4;

	localparam logic [TOKEN_W-1:0] BASE_RESET [REG_BOOKS] =
		'{16'h0001, 16'h0003, 16'h0007, 16'h000F};

	typedef struct packed {
		logic [TOKEN_W-1:0] token_high;
		logic [TOKEN_W-1:0] token_low;
	} cipher_item_t;

	typedef struct packed {
		logic [7:0] plain_out;
		logic       decode_ok;
	} plain_item_t;

	typedef struct packed {
		logic [TOKEN_W-1:0] val;
		logic [3:0]         rot;
	} cand_t;

	// a has the lower rotation count, so it wins ties
	function automatic cand_t pick(cand_t a, cand_t b);
		return (b.val < a.val) ? b : a;
	endfunction

	function automatic int book_w(int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// entry {d, r} holds r mod (d + 1), built by counting
	function automatic logic [255:0][3:0] build_mod_tbl();
		logic [255:0][3:0] tbl;
		logic [3:0]        m;
		tbl = '0;
		for (int d = 0; d < 16; d++) begin
			m = 4'd0;
			for (int r = 0; r < 16; r++) begin
				tbl[d*16 + r] = m;
				if (m == 4'(d)) begin
					m = 4'd0;
				end else begin
					m = m + 4'd1;
				end
			end
		end
		return tbl;
	endfunction

	localparam logic [255:0][3:0] MOD_TBL = build_mod_tbl();

endpackage

>>> hdl/rcbd_stream_if.sv
// Valid/ready stream channel carrying one item of a given payload type.
// Payload types come from rcbd_pkg.
interface rcbd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/rcbd_lane.sv
// One token lane: rotation minimum over a registered compare tree, then base word match.
// Depends on rcbd_pkg.
module rcbd_lane #(
	parameter int  BOOK_COUNT = rcbd_pkg::BOOK_COUNT_DEF,
	localparam int ADDR_W     = rcbd_pkg::book_w(BOOK_COUNT) + 4
) (
	input  logic                         clk,
	input  logic                         en1,
	input  logic                         en2,
	input  logic                         en3,
	input  logic [rcbd_pkg::TOKEN_W-1:0] token,
	input  logic [rcbd_pkg::TOKEN_W-1:0] base [rcbd_pkg::REG_BOOKS],
	output logic                         hit,
	output logic [ADDR_W-1:0]            addr
);
	import rcbd_pkg::*;

	localparam int BOOK_W = book_w(BOOK_COUNT);

	logic [TOKEN_W-1:0] tok_s1;
	cand_t              cand [ROTS];
	cand_t              grp [4];
	cand_t              grp_s2 [4];
	cand_t              best;
	logic               hit_c;
	logic [BOOK_W-1:0]  book_c;
	logic               hit_s3;
	logic [ADDR_W-1:0]  addr_s3;

	always_ff @(posedge clk) begin
		if (en1) begin
			tok_s1 <= token;
		end
	end

	always_comb begin
		for (int i = 0; i < ROTS; i++) begin
			cand[i].val = (tok_s1 >> i) | (tok_s1 << (TOKEN_W - i));
			cand[i].rot = 4'(i);
		end
		for (int g = 0; g < 4; g++) begin
			grp[g] = pick(pick(cand[4*g], cand[4*g+1]), pick(cand[4*g+2], cand[4*g+3]));
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			grp_s2 <= grp;
		end
	end

	always_comb begin
		best   = pick(pick(grp_s2[0], grp_s2[1]), pick(grp_s2[2], grp_s2[3]));
		hit_c  = 1'b0;
		book_c = '0;
		// lowest matching book wins
		for (int b = BOOK_COUNT - 1; b >= 0; b--) begin
			if (base[b] == best.val) begin
				hit_c  = 1'b1;
				book_c = BOOK_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hit_s3  <= hit_c;
			addr_s3 <= {book_c, best.rot};
		end
	end

	assign hit  = hit_s3;
	assign addr = addr_s3;

endmodule

>>> hdl/rcbd_rebuild.sv
// Inverse table builder: per-book Fisher-Yates shuffle, then one inverse entry written per cycle.
// Depends on rcbd_pkg.
module rcbd_rebuild #(
	parameter int  BOOK_COUNT = rcbd_pkg::BOOK_COUNT_DEF,
	localparam int ADDR_W     = rcbd_pkg::book_w(BOOK_COUNT) + 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rcbd_pkg::SALT_W-1:0] salt [rcbd_pkg::REG_BOOKS],
	output logic                        busy,
	output logic                        we,
	output logic [ADDR_W-1:0]           waddr,
	output logic [rcbd_pkg::SYM_W-1:0]  wdata
);
	import rcbd_pkg::*;

	localparam int DEPTH  = BOOK_COUNT * ROTS;
	localparam int BOOK_W = book_w(BOOK_COUNT);

	typedef enum logic [1:0] {S_LOAD, S_PERM, S_INV, S_IDLE} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              we_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [SYM_W-1:0]  wdata_q;
	logic [3:0]        perm_q [BOOK_COUNT][ROTS];
	logic [3:0]        jc;
	logic [3:0]        nib [BOOK_COUNT];
	logic [3:0]        k [BOOK_COUNT];
	logic [BOOK_W-1:0] bsel;

	assign jc   = cnt_q[3:0];
	assign bsel = cnt_q[ADDR_W-1:4];

	always_comb begin
		for (int b = 0; b < BOOK_COUNT; b++) begin
			nib[b] = salt[b][(4'd15 - jc) * 4 +: 4];
			k[b]   = MOD_TBL[{jc, nib[b]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			we_q    <= 1'b0;
			waddr_q <= '0;
			wdata_q <= '0;
		end else if (start) begin
			state_q <= S_LOAD;
			we_q    <= 1'b0;
		end else begin
			we_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_PERM;
				end
				S_PERM: begin
					if (jc == 4'd15) begin
						cnt_q   <= '0;
						state_q <= S_INV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INV: begin
					we_q    <= 1'b1;
					waddr_q <= {bsel, perm_q[bsel][jc]};
					wdata_q <= jc;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < BOOK_COUNT; b++) begin
			if (state_q == S_LOAD) begin
				for (int j = 0; j < ROTS; j++) begin
					perm_q[b][j] <= 4'(j);
				end
			end else if (state_q == S_PERM) begin
				perm_q[b][jc]   <= perm_q[b][k[b]];
				perm_q[b][k[b]] <= perm_q[b][jc];
			end
		end
	end

	assign busy  = (state_q != S_IDLE) || we_q;
	assign we    = we_q;
	assign waddr = waddr_q;
	assign wdata = wdata_q;

endmodule

>>> hdl/rcbd_lookup.sv
// Inverse codebook memory: one write port, two registered read ports (one per lane).
// Depends on rcbd_pkg.
module rcbd_lookup #(
	parameter int  BOOK_COUNT = rcbd_pkg::BOOK_COUNT_DEF,
	localparam int ADDR_W     = rcbd_pkg::book_w(BOOK_COUNT) + 4
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [rcbd_pkg::SYM_W-1:0] wdata,
	input  logic [ADDR_W-1:0]          raddr [2],
	output logic [rcbd_pkg::SYM_W-1:0] rdata [2]
);
	import rcbd_pkg::*;

	localparam int DEPTH = BOOK_COUNT * ROTS;

	logic [SYM_W-1:0] mem [DEPTH];
	logic [SYM_W-1:0] rd_s4 [2];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s4[0] <= mem[raddr[0]];
			rd_s4[1] <= mem[raddr[1]];
		end
	end

	assign rdata = rd_s4;

endmodule

>>> hdl/rotation_codebook_byte_decrypt_unit.sv
// Rotation codebook byte decrypt unit: two token lanes, shared inverse table, merge register.
// Throughput one item per cycle while plain is ready and no table rebuild runs, set by the three
// lane stages, the table read and the output register, each of which advances whenever its
// successor frees up.
// Reset clears control and loads zero salts and base words 1, 3, 7, 15; after reset and after
// each salt write the table rebuild blocks input until the inverse table is rewritten.
module rotation_codebook_byte_decrypt_unit #(
	parameter int BOOK_COUNT = rcbd_pkg::BOOK_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcbd_stream_if.sink                    cipher,
	rcbd_stream_if.source                  plain,
	input  logic                           write_en,
	input  logic [rcbd_pkg::CFG_IDX_W-1:0] reg_index,
	input  logic [rcbd_pkg::SALT_W-1:0]    write_data
);
	import rcbd_pkg::*;

	localparam int ADDR_W = book_w(BOOK_COUNT) + 4;

	logic [SALT_W-1:0]  salt_q [REG_BOOKS];
	logic [TOKEN_W-1:0] base_q [REG_BOOKS];
	logic               start;
	logic               busy;
	logic               tbl_we;
	logic [ADDR_W-1:0]  tbl_waddr;
	logic [SYM_W-1:0]   tbl_wdata;
	logic               en1, en2, en3, en4, en5;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               out_vld_q;
	logic               hit [2];
	logic [ADDR_W-1:0]  addr [2];
	logic [SYM_W-1:0]   sym [2];
	logic               hit_s4;
	logic [7:0]         plain_q;
	logic               ok_q;

	assign start = write_en && (reg_index < REG_BASE0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < REG_BOOKS; b++) begin
				salt_q[b] <= '0;
				base_q[b] <= BASE_RESET[b];
			end
		end else if (write_en) begin
			if (reg_index < REG_BASE0) begin
				salt_q[2'(reg_index - REG_SALT0)] <= write_data;
			end else begin
				base_q[2'(reg_index - REG_BASE0)] <= write_data[TOKEN_W-1:0];
			end
		end
	end

	assign en5 = !out_vld_q || plain.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign cipher.ready = en1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1) vld_s1 <= cipher.valid && !busy;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) out_vld_q <= vld_s4;
		end
	end

	rcbd_rebuild #(.BOOK_COUNT(BOOK_COUNT)) u_rebuild (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.salt   (salt_q),
		.busy   (busy),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (tbl_wdata)
	);

	rcbd_lane #(.BOOK_COUNT(BOOK_COUNT)) u_lane_high (
		.clk   (clk),
		.en1   (en1),
		.en2   (en2),
		.en3   (en3),
		.token (cipher.payload.token_high),
		.base  (base_q),
		.hit   (hit[0]),
		.addr  (addr[0])
	);

	rcbd_lane #(.BOOK_COUNT(BOOK_COUNT)) u_lane_low (
		.clk   (clk),
		.en1   (en1),
		.en2   (en2),
		.en3   (en3),
		.token (cipher.payload.token_low),
		.base  (base_q),
		.hit   (hit[1]),
		.addr  (addr[1])
	);

	rcbd_lookup #(.BOOK_COUNT(BOOK_COUNT)) u_lookup (
		.clk   (clk),
		.en    (en4),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (addr),
		.rdata (sym)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			hit_s4 <= hit[0] && hit[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			plain_q <= hit_s4 ? {sym[0], sym[1]} : 8'h00;
			ok_q    <= hit_s4;
		end
	end

	assign plain.valid             = out_vld_q;
	assign plain.payload.plain_out = plain_q;
	assign plain.payload.decode_ok = ok_q;

endmodule

>>> sim/tb.sv
// Self-checking bench for rotation_codebook_byte_decrypt_unit: random token pairs, mostly rotated
// base words, are checked against a codebook predictor held in a small scoreboard class.
// Depends on hdl/rcbd_pkg.sv, hdl/rcbd_stream_if.sv and the unit itself.
`timescale 1ns / 100ps

import rcbd_pkg::*;

class plain_byte_board;
	localparam int BOOKS = BOOK_COUNT_DEF;

	logic [SALT_W-1:0]  salt [REG_BOOKS];
	logic [TOKEN_W-1:0] base [REG_BOOKS];
	logic [SYM_W-1:0]   inv_book [REG_BOOKS*ROTS];
	plain_item_t        pending_bytes [$];
	int                 errors;

	function new();
		errors = 0;
		for (int b = 0; b < REG_BOOKS; b++) begin
			salt[b] = '0;
			base[b] = BASE_RESET[b];
		end
		for (int i = 0; i < REG_BOOKS*ROTS; i++) begin
			inv_book[i] = '0;
		end
		rebuild();
	endfunction

	// Fisher-Yates over 0..15 per book, salt nibbles taken from the top down
	function void rebuild();
		logic [3:0] perm [ROTS];
		logic [3:0] nib;
		logic [3:0] tmp;
		int         k;
		for (int b = 0; b < BOOKS; b++) begin
			for (int j = 0; j < ROTS; j++) begin
				perm[j] = 4'(j);
			end
			for (int j = 0; j < ROTS; j++) begin
				nib = salt[b][(15-j)*4 +: 4];
				k = int'(nib) % (j + 1);
				tmp = perm[j];
				perm[j] = perm[k];
				perm[k] = tmp;
			end
			for (int j = 0; j < ROTS; j++) begin
				inv_book[b*ROTS + int'(perm[j])] = 4'(j);
			end
		end
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SALT_W-1:0] data);
		if (idx < REG_BASE0) begin
			salt[idx - REG_SALT0] = data;
			rebuild();
		end else begin
			base[idx - REG_BASE0] = data[TOKEN_W-1:0];
		end
	endfunction

	// {smallest right rotation, first rotation count reaching it}
	function logic [TOKEN_W+3:0] min_rot(logic [TOKEN_W-1:0] w);
		logic [TOKEN_W-1:0] cur;
		logic [TOKEN_W-1:0] best;
		logic [3:0]         rot;
		cur = w;
		best = w;
		rot = '0;
		for (int i = 1; i < ROTS; i++) begin
			cur = {cur[0], cur[TOKEN_W-1:1]};
			if (cur < best) begin
				best = cur;
				rot = 4'(i);
			end
		end
		return {best, rot};
	endfunction

	// {hit, symbol}
	function logic [SYM_W:0] token_symbol(logic [TOKEN_W-1:0] tok);
		logic [TOKEN_W+3:0] m;
		m = min_rot(tok);
		for (int b = 0; b < BOOKS; b++) begin
			if (base[b] == m[TOKEN_W+3:4]) begin
				return {1'b1, inv_book[b*ROTS + int'(m[3:0])]};
			end
		end
		return '0;
	endfunction

	function void note_item(cipher_item_t it);
		logic [SYM_W:0] hi;
		logic [SYM_W:0] lo;
		plain_item_t    want;
		hi = token_symbol(it.token_high);
		lo = token_symbol(it.token_low);
		want.decode_ok = hi[SYM_W] & lo[SYM_W];
		want.plain_out = want.decode_ok ? {hi[SYM_W-1:0], lo[SYM_W-1:0]} : 8'h00;
		pending_bytes.push_back(want);
	endfunction

	function void check_byte(plain_item_t got);
		plain_item_t want;
		if (pending_bytes.size() == 0) begin
			$display("%0t: unexpected item: plain_out %02h decode_ok %0b", $time,
				got.plain_out, got.decode_ok);
			errors++;
			return;
		end
		want = pending_bytes.pop_front();
		if (got.plain_out !== want.plain_out) begin
			$display("%0t: plain_out expected %02h got %02h", $time, want.plain_out,
				got.plain_out);
			errors++;
		end
		if (got.decode_ok !== want.decode_ok) begin
			$display("%0t: decode_ok expected %0b got %0b", $time, want.decode_ok,
				got.decode_ok);
			errors++;
		end
	endfunction

	function int outstanding();
		return pending_bytes.size();
	endfunction
endclass

module tb;
	localparam int BOOKS = BOOK_COUNT_DEF;

	logic clk;
	logic arst_n;
	logic write_en;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [SALT_W-1:0]    write_data;

	rcbd_stream_if #(.payload_t(cipher_item_t)) cipher ();
	rcbd_stream_if #(.payload_t(plain_item_t))  plain ();

	rotation_codebook_byte_decrypt_unit #(.BOOK_COUNT(BOOKS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cipher(cipher),
		.plain(plain),
		.write_en(write_en),
		.reg_index(reg_index),
		.write_data(write_data)
	);

	plain_byte_board board = new();

	logic [SALT_W-1:0]  next_salt [REG_BOOKS];
	logic [TOKEN_W-1:0] next_base [REG_BOOKS];
	cipher_item_t       directed [$];
	bit                 quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [TOKEN_W-1:0] rotl(logic [TOKEN_W-1:0] w, int r);
		logic [2*TOKEN_W-1:0] t;
		t = {w, w} << r;
		return t[2*TOKEN_W-1:TOKEN_W];
	endfunction

	function automatic logic [TOKEN_W-1:0] canon_word(logic [TOKEN_W-1:0] w);
		logic [TOKEN_W+3:0] m;
		m = board.min_rot(w);
		return m[TOKEN_W+3:4];
	endfunction

	// mostly valid codewords, some noise, some with one bit flipped
	function automatic logic [TOKEN_W-1:0] pick_token();
		int                 sel;
		logic [TOKEN_W-1:0] w;
		sel = $urandom_range(0, 99);
		w = rotl(board.base[$urandom_range(0, BOOKS-1)], $urandom_range(0, ROTS-1));
		if (sel < 80) return w;
		if (sel < 90) return TOKEN_W'($urandom);
		return w ^ (TOKEN_W'(1) << $urandom_range(0, TOKEN_W-1));
	endfunction

	task automatic offer_cipher(cipher_item_t it);
		int gap;
		gap = quiet ? 0 : idle_span();
		if (gap > 0) begin
			cipher.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cipher.valid   <= 1'b1;
		cipher.payload <= it;
		do @(posedge clk); while (!cipher.ready);
		board.note_item(it);
	endtask

	task automatic wait_rebuild();
		repeat (2) @(posedge clk);
		while (!cipher.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SALT_W-1:0] data);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
		write_en <= 1'b0;
		@(posedge clk);
		if (idx < REG_BASE0) begin
			wait_rebuild();
		end
	endtask

	task automatic run_setting(bit apply_regs, int n_rand);
		cipher_item_t it;
		if (apply_regs) begin
			for (int b = 0; b < REG_BOOKS; b++) begin
				write_reg(REG_SALT0 + CFG_IDX_W'(b), next_salt[b]);
			end
			for (int b = 0; b < REG_BOOKS; b++) begin
				write_reg(REG_BASE0 + CFG_IDX_W'(b), SALT_W'(next_base[b]));
			end
		end
		foreach (directed[i]) begin
			offer_cipher(directed[i]);
		end
		directed.delete();
		repeat (n_rand) begin
			it.token_high = pick_token();
			it.token_low  = pick_token();
			offer_cipher(it);
		end
		cipher.valid <= 1'b0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result side: random stalls, plus two long hold-offs to back up the pipeline
	initial begin : result_sink
		int idle_left;
		int seen;
		int g;
		idle_left = 0;
		seen = 0;
		plain.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (plain.valid && plain.ready) begin
				board.check_byte(plain.payload);
				seen++;
				if (seen == 60 || seen == 400) begin
					idle_left = 250;
				end
			end
			if (idle_left > 0) begin
				idle_left--;
				plain.ready <= 1'b0;
			end else begin
				g = quiet ? 0 : idle_span();
				if (g == 0) begin
					plain.ready <= 1'b1;
				end else begin
					plain.ready <= 1'b0;
					idle_left = g - 1;
				end
			end
		end
	end

	initial begin
		logic [TOKEN_W-1:0] w0;
		logic [TOKEN_W-1:0] w1;
		quiet = 1'b0;
		arst_n         <= 1'b0;
		write_en       <= 1'b0;
		reg_index      <= '0;
		write_data     <= '0;
		cipher.valid   <= 1'b0;
		cipher.payload <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait_rebuild();

		// reset books: every book, both rotation ends, misses on either side
		directed.push_back('{16'h0001, 16'h0001});
		directed.push_back('{16'h8000, 16'h0002});
		directed.push_back('{16'h0003, 16'hC000});
		directed.push_back('{16'h0007, 16'hE000});
		directed.push_back('{16'h000F, 16'hF000});
		directed.push_back('{16'h00F0, 16'h0F00});
		directed.push_back('{16'h0000, 16'h0001});
		directed.push_back('{16'h0001, 16'hFFFF});
		directed.push_back('{16'hFFFF, 16'hFFFF});
		directed.push_back('{16'h0000, 16'h0000});
		directed.push_back('{16'h0005, 16'h0001});
		run_setting(1'b0, 150);

		// extreme salts and bases, periodic base word
		for (int b = 0; b < REG_BOOKS; b++) begin
			next_salt[b] = '1;
		end
		next_base[0] = 16'h0000;
		next_base[1] = 16'hFFFF;
		next_base[2] = 16'h5555;
		next_base[3] = 16'h0001;
		directed.push_back('{16'h0000, 16'hFFFF});
		directed.push_back('{16'h5555, 16'hAAAA});
		directed.push_back('{16'hAAAA, 16'h0000});
		directed.push_back('{16'hFFFF, 16'h0100});
		run_setting(1'b1, 150);

		// random books, no random idling on either side
		for (int b = 0; b < REG_BOOKS; b++) begin
			next_salt[b] = {$urandom, $urandom};
			next_base[b] = canon_word(TOKEN_W'($urandom));
		end
		quiet = 1'b1;
		run_setting(1'b1, 150);
		quiet = 1'b0;

		// duplicate base words: lowest book must win
		w0 = canon_word(TOKEN_W'($urandom));
		w1 = canon_word(TOKEN_W'($urandom));
		for (int b = 0; b < REG_BOOKS; b++) begin
			next_salt[b] = {$urandom, $urandom};
		end
		next_base[0] = w0;
		next_base[1] = w1;
		next_base[2] = w0;
		next_base[3] = w1;
		directed.push_back('{rotl(w0, 3), w1});
		directed.push_back('{w1, rotl(w0, 15)});
		run_setting(1'b1, 150);

		// raw random bases, mostly unreachable
		for (int b = 0; b < REG_BOOKS; b++) begin
			next_salt[b] = {$urandom, $urandom};
			next_base[b] = TOKEN_W'($urandom);
		end
		run_setting(1'b1, 100);

		next_salt[0] = '0;
		next_salt[1] = '1;
		next_salt[2] = {$urandom, $urandom};
		next_salt[3] = 64'h0123_4567_89AB_CDEF;
		next_base[0] = 16'h7FFF;
		next_base[1] = 16'h0001;
		next_base[2] = 16'h0F0F;
		next_base[3] = 16'h0000;
		run_setting(1'b1, 200);

		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
